FILE: rtl/bilinear_integer_upscaler_defines.svh
// Assertion macros shared by the checker files.
// Depends on nothing; included by name where assertions are written.
`ifndef BILINEAR_INTEGER_UPSCALER_DEFINES_SVH
`define BILINEAR_INTEGER_UPSCALER_DEFINES_SVH

// Same-cycle implication on the rising clock, quiet during reset.
`define BLU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blu assertion failed");

// Next-cycle implication on the rising clock, quiet during reset.
`define BLU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blu assertion failed");

`endif

FILE: rtl/blu_pkg.sv
// Shared constants, types and helper functions of the bilinear upscaler.
// Depends on nothing; used by blu_blend and the top level.
package blu_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int MAX_CHANNELS = 4;
   localparam int MAX_FACTOR   = 4;
   localparam int CSR_DATA_W   = 13;
   localparam int RECIP3_SH    = 24;
   localparam int RECIP36      = 466034;

   typedef enum logic [1:0] {
      CSR_WIDTH    = 2'd0,
      CSR_HEIGHT   = 2'd1,
      CSR_CHANNELS = 2'd2,
      CSR_FACTOR   = 2'd3
   } csr_type;

   typedef struct packed {
      logic [3:0]  cmask;
      logic [2:0]  fac;
      logic [11:0] col;
      logic [13:0] row;
      logic        run_last;
      logic        frame_done;
   } meta_type;

   typedef struct packed {
      logic [31:0] p00;
      logic [31:0] p10;
      logic [31:0] p01;
      logic [31:0] p11;
      logic [2:0]  ax;
      logic [2:0]  ay;
      meta_type    meta;
   } tap_type;

   typedef struct packed {
      logic       neg;
      logic [2:0] wt;
   } axis_type;

   // first offset inside a tile that lands on this source index
   function automatic logic signed [2:0] span_lo(input logic [2:0] fac);
      logic signed [2:0] r;
      case (fac)
         3'd2, 3'd3: r = -3'sd1;
         3'd4:       r = -3'sd2;
         default:    r = 3'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [2:0] span_hi(input logic [2:0] fac);
      logic signed [2:0] r;
      case (fac)
         3'd3, 3'd4: r = 3'sd1;
         default:    r = 3'sd0;
      endcase
      return r;
   endfunction

   // weight of the upper neighbour and whether the lower one is the previous index
   function automatic axis_type axis_wt(input logic [2:0] fac, input logic signed [2:0] k);
      logic signed [4:0] t;
      logic signed [4:0] d;
      logic signed [4:0] s;
      axis_type r;
      t = $signed({k[2], k, 1'b1}) - $signed({2'b00, fac});
      d = $signed({1'b0, fac, 1'b0});
      s = t + d;
      r.neg = t[4];
      r.wt  = t[4] ? s[2:0] : t[2:0];
      return r;
   endfunction

endpackage

FILE: rtl/blu_if.sv
// Word channels of the bilinear upscaler: source pixel in, output pixel out.
// Depends on nothing.
interface blu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_ch0;
   logic [7:0] src_ch1;
   logic [7:0] src_ch2;
   logic [7:0] src_ch3;
   modport source (output valid, src_ch0, src_ch1, src_ch2, src_ch3, input ready);
   modport sink (input valid, src_ch0, src_ch1, src_ch2, src_ch3, output ready);
endinterface

interface blu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_ch0;
   logic [7:0]  out_ch1;
   logic [7:0]  out_ch2;
   logic [7:0]  out_ch3;
   logic [11:0] out_col;
   logic [13:0] out_row;
   logic        run_last;
   logic        frame_done;
   modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_col, out_row,
                   run_last, frame_done, input ready);
   modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_col, out_row,
                 run_last, frame_done, output ready);
endinterface

FILE: rtl/blu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module blu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: rtl/blu_blend.sv
// Blend pipeline: horizontal products, vertical products, rounding divide, output word.
// Depends on blu_pkg and blu_rsp_if.
module blu_blend (
   input  logic             clock,
   input  logic             reset,
   input  logic             tap_valid,
   input  blu_pkg::tap_type tap,
   output logic             adv,
   blu_rsp_if.source        rsp_ch
);

   logic                  s2_valid_ff;
   logic [3:0][10:0]      top_ff, top_in;
   logic [3:0][10:0]      bot_ff, bot_in;
   logic [2:0]            ay_ff;
   blu_pkg::meta_type     s2_meta_ff;
   logic                  s3_valid_ff;
   logic [3:0][13:0]      val_ff, val_in;
   blu_pkg::meta_type     s3_meta_ff;
   logic                  out_valid_ff;
   logic [3:0][7:0]       out_ff, out_in;
   blu_pkg::meta_type     out_meta_ff;

   logic [3:0] dx;
   logic [3:0] dy;
   logic [15:0] rnd;

   assign adv = !out_valid_ff || rsp_ch.ready;
   assign dx  = {tap.meta.fac, 1'b0};
   assign dy  = {s2_meta_ff.fac, 1'b0};
   assign rnd = 16'(s2_meta_ff.fac) * 16'(s2_meta_ff.fac) * 16'd2;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         top_in[k] = 11'(12'(tap.p00[8*k +: 8]) * 12'(dx - 4'(tap.ax))
                       + 12'(tap.p10[8*k +: 8]) * 12'(tap.ax));
         bot_in[k] = 11'(12'(tap.p01[8*k +: 8]) * 12'(dx - 4'(tap.ax))
                       + 12'(tap.p11[8*k +: 8]) * 12'(tap.ax));
         val_in[k] = 14'(16'(top_ff[k]) * 16'(dy - 4'(ay_ff))
                       + 16'(bot_ff[k]) * 16'(ay_ff) + rnd);
      end
   end

   always_comb begin
      logic [33:0] prod;
      logic [13:0] q;
      for (int k = 0; k < 4; k++) begin
         prod = 34'(val_ff[k]) * 34'(blu_pkg::RECIP36);
         case (s3_meta_ff.fac)
            3'd2:    q = val_ff[k] >> 4;
            3'd3:    q = 14'(prod >> blu_pkg::RECIP3_SH);
            3'd4:    q = val_ff[k] >> 6;
            default: q = val_ff[k] >> 2;
         endcase
         if (!s3_meta_ff.cmask[k]) begin
            out_in[k] = 8'd0;
         end else if (q > 14'd255) begin
            out_in[k] = 8'd255;
         end else begin
            out_in[k] = q[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff  <= tap_valid;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         top_ff      <= top_in;
         bot_ff      <= bot_in;
         ay_ff       <= tap.ay;
         s2_meta_ff  <= tap.meta;
         val_ff      <= val_in;
         s3_meta_ff  <= s2_meta_ff;
         out_ff      <= out_in;
         out_meta_ff <= s3_meta_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_ch0    = out_ff[0];
   assign rsp_ch.out_ch1    = out_ff[1];
   assign rsp_ch.out_ch2    = out_ff[2];
   assign rsp_ch.out_ch3    = out_ff[3];
   assign rsp_ch.out_col    = out_meta_ff.col;
   assign rsp_ch.out_row    = out_meta_ff.row;
   assign rsp_ch.run_last   = out_meta_ff.run_last;
   assign rsp_ch.frame_done = out_meta_ff.frame_done;

endmodule

FILE: rtl/bilinear_integer_upscaler.sv
// Top level of the bilinear integer upscaler: registers, line memory, tile sequencer.
// Depends on blu_pkg, blu_if, blu_ram and blu_blend.
//
//   channel | dir | handshake       | word
//   req_ch  | in  | valid/ready     | src_ch0..src_ch3
//   rsp_ch  | out | valid/ready     | out_ch0..3, out_col, out_row, run_last, frame_done
//   csr     | in  | csr_wr_en only  | csr_index, csr_wdata
//
// Each source word yields N outputs (factor squared on average, up to 36 at the
// bottom-right edge); no new word is accepted until all N are emitted, and the sequencer
// emits one output per cycle; a stalled rsp_ch freezes the sequencer and the blend
// pipeline. The previous row sits in a line memory read once per word.
// Reset is synchronous; no clearing pass, a register write restarts the frame.
module bilinear_integer_upscaler #(
   parameter int MAX_WIDTH = blu_pkg::MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   blu_req_if.sink                       req_ch,
   blu_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [blu_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [2:0]  chan_ff;
   logic [2:0]  fac_ff;

   logic [AW-1:0] wm1;
   logic [11:0]   hm1;
   logic [2:0]    chan_sat;
   logic [2:0]    fac_sat;
   logic [3:0]    cmask;

   state_type         state_ff;
   logic [AW-1:0]     col_ff;
   logic [11:0]       row_ff;
   logic              first_ff;
   logic [31:0]       cur_ff;
   logic [31:0]       left_ff;
   logic [31:0]       al_ff;
   logic [11:0]       fx_ff;
   logic [13:0]       fy_ff;
   logic              cfirst_ff, clast_ff, rfirst_ff, rlast_ff;
   logic signed [2:0] kx_ff, kx_lo_ff, kx_hi_ff, ky_ff, ky_hi_ff;
   logic              tap_valid_ff;
   blu_pkg::tap_type  tap_ff, tap_in;

   logic        accept;
   logic        adv;
   logic [31:0] cur_in;
   logic [31:0] above;
   logic        x_end, y_end;

   function automatic logic [31:0] pick(input logic rcur, input logic ccur,
                                        input logic [31:0] p_cur, input logic [31:0] p_left,
                                        input logic [31:0] p_up, input logic [31:0] p_upleft);
      logic [31:0] r;
      if (rcur) begin
         r = ccur ? p_cur : p_left;
      end else begin
         r = ccur ? p_up : p_upleft;
      end
      return r;
   endfunction

   always_comb begin
      if (width_ff == 11'd0) begin
         wm1 = '0;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         wm1 = AW'(MAX_WIDTH - 1);
      end else begin
         wm1 = AW'(width_ff - 11'd1);
      end
      if (height_ff == 13'd0) begin
         hm1 = '0;
      end else if (32'(height_ff) > blu_pkg::MAX_HEIGHT) begin
         hm1 = 12'(blu_pkg::MAX_HEIGHT - 1);
      end else begin
         hm1 = 12'(height_ff - 13'd1);
      end
      if (chan_ff == 3'd0) begin
         chan_sat = 3'd1;
      end else if (32'(chan_ff) > blu_pkg::MAX_CHANNELS) begin
         chan_sat = 3'(blu_pkg::MAX_CHANNELS);
      end else begin
         chan_sat = chan_ff;
      end
      if (fac_ff == 3'd0) begin
         fac_sat = 3'd1;
      end else if (32'(fac_ff) > blu_pkg::MAX_FACTOR) begin
         fac_sat = 3'(blu_pkg::MAX_FACTOR);
      end else begin
         fac_sat = fac_ff;
      end
      for (int k = 0; k < 4; k++) begin
         cmask[k] = 3'(k) < chan_sat;
      end
   end

   assign accept       = (state_ff == ST_IDLE) && req_ch.valid;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign cur_in       = {cmask[3] ? req_ch.src_ch3 : 8'd0, cmask[2] ? req_ch.src_ch2 : 8'd0,
                          cmask[1] ? req_ch.src_ch1 : 8'd0, cmask[0] ? req_ch.src_ch0 : 8'd0};
   assign x_end        = (kx_ff == kx_hi_ff);
   assign y_end        = (ky_ff == ky_hi_ff);

   blu_ram #(
      .WIDTH (32),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (cur_in),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above)
   );

   always_comb begin
      blu_pkg::axis_type wx;
      blu_pkg::axis_type wy;
      logic lcx, hcx, lcy, hcy;
      wx = blu_pkg::axis_wt(fac_sat, kx_ff);
      wy = blu_pkg::axis_wt(fac_sat, ky_ff);
      if (wx.neg && cfirst_ff) begin
         wx = '0;
      end
      if (wy.neg && rfirst_ff) begin
         wy = '0;
      end
      lcx = !wx.neg;
      hcx = wx.neg || clast_ff;
      lcy = !wy.neg;
      hcy = wy.neg || rlast_ff;
      tap_in.p00 = pick(lcy, lcx, cur_ff, left_ff, above, al_ff);
      tap_in.p10 = (wx.wt != 3'd0) ? pick(lcy, hcx, cur_ff, left_ff, above, al_ff) : '0;
      tap_in.p01 = (wy.wt != 3'd0) ? pick(hcy, lcx, cur_ff, left_ff, above, al_ff) : '0;
      tap_in.p11 = (wx.wt != 3'd0 && wy.wt != 3'd0)
                   ? pick(hcy, hcx, cur_ff, left_ff, above, al_ff) : '0;
      tap_in.ax  = wx.wt;
      tap_in.ay  = wy.wt;
      tap_in.meta.cmask      = cmask;
      tap_in.meta.fac        = fac_sat;
      tap_in.meta.col        = fx_ff + 12'($signed(kx_ff));
      tap_in.meta.row        = fy_ff + 14'($signed(ky_ff));
      tap_in.meta.run_last   = x_end && y_end;
      tap_in.meta.frame_done = x_end && y_end && clast_ff && rlast_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 11'd1;
         height_ff    <= 13'd1;
         chan_ff      <= 3'd1;
         fac_ff       <= 3'd1;
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         first_ff     <= 1'b1;
         tap_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (blu_pkg::csr_type'(csr_index))
               blu_pkg::CSR_WIDTH:    width_ff  <= csr_wdata[10:0];
               blu_pkg::CSR_HEIGHT:   height_ff <= csr_wdata[12:0];
               blu_pkg::CSR_CHANNELS: chan_ff   <= csr_wdata[2:0];
               blu_pkg::CSR_FACTOR:   fac_ff    <= csr_wdata[2:0];
               default:               width_ff  <= width_ff;
            endcase
            col_ff   <= '0;
            row_ff   <= '0;
            first_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (adv) begin
                  tap_valid_ff <= 1'b0;
               end
               if (accept) begin
                  first_ff  <= 1'b0;
                  if (col_ff == wm1) begin
                     col_ff <= '0;
                     row_ff <= (row_ff == hm1) ? 12'd0 : row_ff + 12'd1;
                  end else begin
                     col_ff <= col_ff + AW'(1);
                  end
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (adv) begin
                  tap_valid_ff <= 1'b1;
                  if (x_end && y_end) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff    <= cur_in;
         left_ff   <= first_ff ? 32'd0 : cur_ff;
         al_ff     <= first_ff ? 32'd0 : above;
         fx_ff     <= 12'(15'(fac_sat) * 15'(col_ff));
         fy_ff     <= 14'(15'(fac_sat) * 15'(row_ff));
         cfirst_ff <= (col_ff == '0);
         clast_ff  <= (col_ff == wm1);
         rfirst_ff <= (row_ff == 12'd0);
         rlast_ff  <= (row_ff == hm1);
         kx_lo_ff  <= (col_ff == '0) ? 3'sd0 : blu_pkg::span_lo(fac_sat);
         kx_ff     <= (col_ff == '0) ? 3'sd0 : blu_pkg::span_lo(fac_sat);
         kx_hi_ff  <= (col_ff == wm1) ? $signed(fac_sat - 3'd1) : blu_pkg::span_hi(fac_sat);
         ky_ff     <= (row_ff == 12'd0) ? 3'sd0 : blu_pkg::span_lo(fac_sat);
         ky_hi_ff  <= (row_ff == hm1) ? $signed(fac_sat - 3'd1) : blu_pkg::span_hi(fac_sat);
      end else if (state_ff == ST_RUN && adv) begin
         if (x_end) begin
            kx_ff <= kx_lo_ff;
            ky_ff <= ky_ff + 3'sd1;
         end else begin
            kx_ff <= kx_ff + 3'sd1;
         end
      end
      if (adv) begin
         tap_ff <= tap_in;
      end
   end

   blu_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .tap_valid (tap_valid_ff),
      .tap       (tap_ff),
      .adv       (adv),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: rtl/blu_checker.sv
// Port-level checks of the bilinear upscaler, bound to the top level.
// Depends on bilinear_integer_upscaler_defines.svh.
`include "bilinear_integer_upscaler_defines.svh"

module blu_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_run_last,
   input logic rsp_frame_done
);

   `BLU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BLU_ASSERT_NOW(a_frame_last, clock, reset, rsp_valid && rsp_frame_done, rsp_run_last)
   `BLU_ASSERT_NEXT(a_one_word, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind bilinear_integer_upscaler blu_port_checker u_blu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_run_last   (rsp_ch.run_last),
   .rsp_frame_done (rsp_ch.frame_done)
);
